// File: rtl/dual_frame_parser_crc_xor_assert.svh
// Assertion macros shared by the frame parser RTL.
// No dependencies; included where assertions are written.
`ifndef DUAL_FRAME_PARSER_CRC_XOR_ASSERT_SVH
`define DUAL_FRAME_PARSER_CRC_XOR_ASSERT_SVH

// Same-cycle implication.
`define DFPCX_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dfpcx assertion failed");

// Next-cycle implication.
`define DFPCX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dfpcx assertion failed");

`endif

// File: rtl/dfpcx_pkg.sv
// Package for the dual frame parser: transaction types, codes and checksum helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dfpcx_pkg;

    localparam logic [7:0]  HDR_CTRL = 8'hAA;
    localparam logic [7:0]  HDR_SYNC = 8'h55;
    localparam logic [7:0]  HDR_STRM = 8'hBB;
    localparam logic [15:0] CRC_POLY = 16'h8005;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_CTRL_OK = 3'd1,
        EV_STRM_OK = 3'd2,
        EV_CRC_BAD = 3'd3,
        EV_XOR_BAD = 3'd4,
        EV_LEN_BAD = 3'd5
    } t_event;

    typedef enum logic [11:0] {
        PH_HDR   = 12'b0000_0000_0001,
        PH_HDR2  = 12'b0000_0000_0010,
        PH_SEQ   = 12'b0000_0000_0100,
        PH_CMD   = 12'b0000_0000_1000,
        PH_LEN   = 12'b0000_0001_0000,
        PH_DATA  = 12'b0000_0010_0000,
        PH_CRCH  = 12'b0000_0100_0000,
        PH_CRCL  = 12'b0000_1000_0000,
        PH_MASK  = 12'b0001_0000_0000,
        PH_SLEN  = 12'b0010_0000_0000,
        PH_SDATA = 12'b0100_0000_0000,
        PH_XOR   = 12'b1000_0000_0000
    } t_phase;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         event_res;
        logic [7:0]         frame_seq;
        logic [7:0]         frame_cmd;
        logic [7:0]         frame_length;
        logic [7:0]         frame_mask;
        logic [7:0]         payload_out;
        logic signed [15:0] sample_out;
    } t_out_item;

    // Right-shifting CRC-16 update with CRC_POLY (16'h8005) as given, not bit-reversed, one byte.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++) begin
            n = n + {3'd0, v[i]};
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// File: rtl/dfpcx_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dfpcx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/dual_frame_parser_crc_xor.sv
// Pipeline: an accepted input transaction is registered in r_s1, then its result in r_out_item.
// Throughput: one transaction per cycle; the stage behind the payload RAM read stalls
// only while the output register holds an untaken result.
// Reset: i_rst_n synchronous, active low; clears parser state, last-frame fields and valid flags.
// Payload and sample RAMs are not cleared and are available right after reset.
`timescale 1ns / 1ps
`default_nettype none

`include "dual_frame_parser_crc_xor_assert.svh"

module dual_frame_parser_crc_xor
    import dfpcx_pkg::*;
#(
    parameter int MAX_PAYLOAD  = 256,
    parameter int MAX_CHANNELS = 8
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_item
);

    localparam int PAW   = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CHAW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam logic [8:0] PAY_LIM = 9'(MAX_PAYLOAD);
    localparam logic [8:0] STR_LIM = 9'(2 * MAX_CHANNELS);

    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] seq;
        logic [7:0] cmd;
        logic [7:0] len;
        logic [7:0] mask;
        logic       pay_ok;
        logic       smp_ok;
        logic       smp_fwd;
    } t_s1;

    // Parser state
    t_phase      r_phase, n_phase;
    logic [7:0]  r_seq, n_seq, r_cmd, n_cmd, r_len, n_len, r_cnt, n_cnt;
    logic [7:0]  r_crch, n_crch, r_mask, n_mask, r_xor, n_xor;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_dseq, n_dseq, r_dcmd, n_dcmd, r_dlen, n_dlen, r_dmask, n_dmask;
    t_event      ev;
    logic        clr;

    // Pipeline
    logic        r_s1_valid;
    t_s1         r_s1, n_s1;
    logic        r_out_valid;
    t_out_item   r_out_item;
    logic        s1_adv, in_acc, byte_acc, rd_acc;

    // RAM ports
    logic             pay_we, str_we_e, str_we_o;
    logic [PAW-1:0]   pay_waddr;
    logic [CHAW-1:0]  str_waddr;
    logic [7:0]       pay_rdata;
    logic [15:0]      str_rdata;
    logic [7:0]       r_shi;
    logic             smp_pend;
    logic [7:0]       b;
    logic [7:0]       cnt_inc;

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;
    assign byte_acc   = in_acc && !i_in_item.kind;
    assign rd_acc     = in_acc && i_in_item.kind;
    assign b          = i_in_item.rx_byte;
    assign cnt_inc    = r_cnt + 8'd1;

    always_comb begin
        n_phase = r_phase;
        n_seq   = r_seq;
        n_cmd   = r_cmd;
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_crch  = r_crch;
        n_mask  = r_mask;
        n_xor   = r_xor;
        n_crc   = r_crc;
        n_dseq  = r_dseq;
        n_dcmd  = r_dcmd;
        n_dlen  = r_dlen;
        n_dmask = r_dmask;
        ev      = EV_NONE;
        clr     = 1'b0;
        pay_we  = 1'b0;
        str_we_e = 1'b0;
        str_we_o = 1'b0;
        case (r_phase)
            PH_HDR: begin
                if (b == HDR_CTRL) begin
                    clr = 1'b1;
                    n_phase = PH_HDR2;
                end else if (b == HDR_STRM) begin
                    clr = 1'b1;
                    n_phase = PH_MASK;
                end
            end
            PH_HDR2: begin
                clr = 1'b1;
                if (b == HDR_SYNC) begin
                    clr = 1'b0;
                    n_phase = PH_SEQ;
                end else if (b == HDR_CTRL) begin
                    n_phase = PH_HDR2;
                end else if (b == HDR_STRM) begin
                    n_phase = PH_MASK;
                end else begin
                    n_phase = PH_HDR;
                end
            end
            PH_SEQ: begin
                n_seq   = b;
                n_crc   = crc_byte(CRC_INIT, b);
                n_phase = PH_CMD;
            end
            PH_CMD: begin
                n_cmd   = b;
                n_crc   = crc_byte(r_crc, b);
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                n_len   = b;
                n_cnt   = 8'd0;
                n_crc   = crc_byte(r_crc, b);
                n_phase = (b == 8'd0) ? PH_CRCH : PH_DATA;
            end
            PH_DATA: begin
                pay_we = ({1'b0, r_cnt} < PAY_LIM);
                n_crc  = crc_byte(r_crc, b);
                n_cnt  = cnt_inc;
                if (cnt_inc >= r_len) begin
                    n_phase = PH_CRCH;
                end
            end
            PH_CRCH: begin
                n_crch  = b;
                n_phase = PH_CRCL;
            end
            PH_CRCL: begin
                clr     = 1'b1;
                n_phase = PH_HDR;
                if ({r_crch, b} == r_crc) begin
                    n_dseq = r_seq;
                    n_dcmd = r_cmd;
                    n_dlen = r_len;
                    ev     = EV_CTRL_OK;
                end else begin
                    ev = EV_CRC_BAD;
                end
            end
            PH_MASK: begin
                n_mask  = b;
                n_xor   = b;
                n_phase = PH_SLEN;
            end
            PH_SLEN: begin
                n_len = b;
                n_cnt = 8'd0;
                if (b != {3'd0, popcount8(r_mask), 1'b0}) begin
                    clr     = 1'b1;
                    n_phase = PH_HDR;
                    ev      = EV_LEN_BAD;
                end else begin
                    n_xor   = r_xor ^ b;
                    n_phase = (b == 8'd0) ? PH_XOR : PH_SDATA;
                end
            end
            PH_SDATA: begin
                str_we_e = ({1'b0, r_cnt} < STR_LIM) && !r_cnt[0];
                str_we_o = ({1'b0, r_cnt} < STR_LIM) && r_cnt[0];
                n_xor    = r_xor ^ b;
                n_cnt    = cnt_inc;
                if (cnt_inc >= r_len) begin
                    n_phase = PH_XOR;
                end
            end
            PH_XOR: begin
                clr     = 1'b1;
                n_phase = PH_HDR;
                if (b == r_xor) begin
                    n_dmask = r_mask;
                    ev      = EV_STRM_OK;
                end else begin
                    ev = EV_XOR_BAD;
                end
            end
            default: begin
                clr     = 1'b1;
                n_phase = PH_HDR;
            end
        endcase
        if (clr) begin
            n_seq  = 8'd0;
            n_cmd  = 8'd0;
            n_len  = 8'd0;
            n_cnt  = 8'd0;
            n_crch = 8'd0;
            n_mask = 8'd0;
            n_xor  = 8'd0;
            n_crc  = CRC_INIT;
        end
    end

    assign pay_waddr = r_cnt[PAW-1:0];
    assign str_waddr = r_cnt[CHAW:1];

    // high byte of the current sample is held in r_shi, not yet in the RAM
    assign smp_pend  = (r_phase == PH_SDATA) && r_cnt[0] && ({1'b0, r_cnt} < STR_LIM);

    always_comb begin
        n_s1.event_res = byte_acc ? ev : EV_NONE;
        n_s1.seq       = byte_acc ? n_dseq : r_dseq;
        n_s1.cmd       = byte_acc ? n_dcmd : r_dcmd;
        n_s1.len       = byte_acc ? n_dlen : r_dlen;
        n_s1.mask      = byte_acc ? n_dmask : r_dmask;
        n_s1.pay_ok    = i_in_item.kind && ({1'b0, i_in_item.read_index} < PAY_LIM);
        n_s1.smp_ok    = i_in_item.kind
                         && ({1'b0, i_in_item.read_index} < 9'(MAX_CHANNELS));
        n_s1.smp_fwd   = smp_pend && (i_in_item.read_index[CHAW-1:0] == str_waddr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR;
            r_seq   <= 8'd0;
            r_cmd   <= 8'd0;
            r_len   <= 8'd0;
            r_cnt   <= 8'd0;
            r_crch  <= 8'd0;
            r_mask  <= 8'd0;
            r_xor   <= 8'd0;
            r_crc   <= CRC_INIT;
            r_dseq  <= 8'd0;
            r_dcmd  <= 8'd0;
            r_dlen  <= 8'd0;
            r_dmask <= 8'd0;
        end else if (byte_acc) begin
            r_phase <= n_phase;
            r_seq   <= n_seq;
            r_cmd   <= n_cmd;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_crch  <= n_crch;
            r_mask  <= n_mask;
            r_xor   <= n_xor;
            r_crc   <= n_crc;
            r_dseq  <= n_dseq;
            r_dcmd  <= n_dcmd;
            r_dlen  <= n_dlen;
            r_dmask <= n_dmask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (byte_acc && str_we_e) begin
            r_shi <= b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= n_s1;
        end
        if (s1_adv) begin
            r_out_item.event_res    <= r_s1.event_res;
            r_out_item.frame_seq    <= r_s1.seq;
            r_out_item.frame_cmd    <= r_s1.cmd;
            r_out_item.frame_length <= r_s1.len;
            r_out_item.frame_mask   <= r_s1.mask;
            r_out_item.payload_out  <= r_s1.pay_ok ? pay_rdata : 8'd0;
            r_out_item.sample_out   <= !r_s1.smp_ok  ? 16'd0 :
                                       r_s1.smp_fwd ? {r_shi, str_rdata[7:0]} : str_rdata;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    dfpcx_ram #(.WIDTH(8), .DEPTH(MAX_PAYLOAD)) u_pay_ram (
        .i_clk   (i_clk),
        .i_we    (byte_acc && pay_we),
        .i_waddr (pay_waddr),
        .i_wdata (b),
        .i_re    (rd_acc),
        .i_raddr (i_in_item.read_index[PAW-1:0]),
        .o_rdata (pay_rdata)
    );

    // Samples, written as a word when the low byte arrives
    dfpcx_ram #(.WIDTH(16), .DEPTH(MAX_CHANNELS)) u_smp_ram (
        .i_clk   (i_clk),
        .i_we    (byte_acc && str_we_o),
        .i_waddr (str_waddr),
        .i_wdata ({r_shi, b}),
        .i_re    (rd_acc),
        .i_raddr (i_in_item.read_index[CHAW-1:0]),
        .o_rdata (str_rdata)
    );

    `DFPCX_ASSERT_NEXT(a_acc_fills_s1, i_clk, i_rst_n, in_acc, r_s1_valid)
    `DFPCX_ASSERT_NOW(a_stall_blocks_in, i_clk, i_rst_n,
                      r_s1_valid && r_out_valid && !i_out_ready, !o_in_ready)
    `DFPCX_ASSERT_NOW(a_event_no_data, i_clk, i_rst_n,
                      o_out_valid && (o_out_item.event_res != EV_NONE),
                      (o_out_item.payload_out == 8'd0) && (o_out_item.sample_out == 16'sd0))

endmodule

`default_nettype wire
